### sv/assert_macros.svh
// assertion macros for the rtl files, used by gcdc_ctrl
// depends on nothing; included where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a property holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property also while reset is active
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### sv/gcdc_pkg.sv
// shared types, constants and the sigmoid table of the gated depthwise conv
// depends on nothing
package gcdc_pkg;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // command from controller to datapath
   typedef struct packed {
      logic capture;     // latch the accepted word
      logic gate_mul;    // compute gated value
      logic acc_clear;   // clear accumulator
      logic mac;         // one multiply-accumulate step
      logic finish;      // round and saturate into output stage
      logic hist_wr;     // write one history slot
      logic wt_wr;       // write a weight
      logic rd_issue;    // latch the age of the tap read for current tap
   } gcdc_cmd_type;

   // sigmoid of bin centre (2*(i-128)+1)/32 in Q0.15, built at elaboration
   // quotient 2^48 / (2^32 + e) found by restoring long division
   function automatic logic [255:0][15:0] build_sigmoid_table();
      logic [255:0][15:0] tbl;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] pos;
      tbl = '0;
      e = 64'd4162825044;
      for (int j = 0; j < 128; j++) begin
         den = (64'd1 << 32) + e;
         rem = 64'd1 << 48;
         quo = '0;
         for (int i = 16; i >= 0; i--) begin
            if (rem >= (den << i)) begin
               rem = rem - (den << i);
               quo[i] = 1'b1;
            end
         end
         pos = (quo + 64'd1) >> 1;
         tbl[128 + j] = (pos > 64'd32767) ? 16'd32767 : pos[15:0];
         tbl[127 - j] = 16'(64'd32768 - pos);
         e = (e * 64'd4034748382 + 64'h8000_0000) >> 32;
      end
      return tbl;
   endfunction

   localparam logic [255:0][15:0] SIGMOID_TABLE = build_sigmoid_table();

endpackage

### sv/glu_causal_depthwise_conv.sv
// top level of the gated causal depthwise convolution
// depends on gcdc_pkg, gcdc_ctrl, gcdc_datapath, gcdc_ram
//
// one word in, at most one word out. a sample word (opcode 1) is gated by
// a*sigmoid(b) with a 256-entry table, convolved over the channel's last
// taps_in_use gated values with per-channel weights, rounded and saturated.
// a weight word (opcode 0) writes one tap and gives no result. for a sample,
// one shared mac walks the taps one memory read per cycle, then the history
// line is shifted one slot per cycle through the single-write history ram.
// a result word not yet taken holds the next sample at its rounding step.
// history and weights must be written before they are read.
module glu_causal_depthwise_conv import gcdc_pkg::*; #(
   parameter int CHANNELS = 512,
   parameter int KERNEL   = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [8:0]  req_channel,
   input  logic [3:0]  req_tap,
   input  logic signed [15:0] req_tap_weight,
   input  logic signed [15:0] req_content_half,
   input  logic signed [15:0] req_gate_half,
   input  logic        req_last_channel,
   input  logic        req_new_sequence,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_out_channel,
   output logic signed [15:0] rsp_conv_out,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_taps_in_use
);
   gcdc_cmd_type cmd, cmd_dp;
   logic [4:0] tap_idx, taps_k, frames;
   logic ld_ok_ff;

   // out-of-range weight loads are dropped
   always_ff @(posedge clock) begin
      if (reset) ld_ok_ff <= 1'b0;
      else if (cmd.capture)
         ld_ok_ff <= (11'(req_channel) < 11'(CHANNELS)) && (6'(req_tap) < 6'(KERNEL));
   end
   always_comb begin
      cmd_dp = cmd;
      cmd_dp.wt_wr = cmd.wt_wr && ld_ok_ff;
   end

   gcdc_ctrl #(.CHANNELS(CHANNELS), .KERNEL(KERNEL)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_channel(req_channel),
      .req_last_channel(req_last_channel), .req_new_sequence(req_new_sequence),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_taps_in_use(csr_taps_in_use),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd),
      .tap_idx(tap_idx), .taps_k(taps_k), .frames(frames));

   gcdc_datapath #(.CHANNELS(CHANNELS), .KERNEL(KERNEL)) u_dp (
      .clock(clock), .cmd(cmd_dp), .tap_idx(tap_idx), .taps_k(taps_k),
      .frames(frames), .req_channel(req_channel), .req_tap(req_tap),
      .req_tap_weight(req_tap_weight), .req_content_half(req_content_half),
      .req_gate_half(req_gate_half), .rsp_out_channel(rsp_out_channel),
      .rsp_conv_out(rsp_conv_out), .rsp_saturated(rsp_saturated));
endmodule

### sv/gcdc_ram.sv
// generic single-port-write, single-read ram with registered read
// depends on nothing
module gcdc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### sv/gcdc_datapath.sv
// datapath: gating multiplier, shared mac, weight and history memories
// depends on gcdc_pkg and gcdc_ram
module gcdc_datapath import gcdc_pkg::*; #(
   parameter int CHANNELS = 512,
   parameter int KERNEL   = 9
) (
   input  logic         clock,
   input  gcdc_cmd_type cmd,
   input  logic [4:0]   tap_idx,      // current tap j
   input  logic [4:0]   taps_k,       // effective kernel length
   input  logic [4:0]   frames,       // frames seen
   input  logic [8:0]   req_channel,
   input  logic [3:0]   req_tap,
   input  logic signed [15:0] req_tap_weight,
   input  logic signed [15:0] req_content_half,
   input  logic signed [15:0] req_gate_half,
   output logic [8:0]   rsp_out_channel,
   output logic signed [15:0] rsp_conv_out,
   output logic         rsp_saturated
);
   localparam int SLOTS  = (KERNEL > 1) ? KERNEL - 1 : 1;
   localparam int WDEPTH = CHANNELS * KERNEL;
   localparam int HDEPTH = CHANNELS * SLOTS;
   localparam int WAW    = $clog2(WDEPTH);
   localparam int HAW    = $clog2(HDEPTH);

   logic [8:0]         ch_ff;
   logic [3:0]         tap_ff;
   logic signed [15:0] wt_ff, a_ff, b_ff, g_ff;
   logic signed [40:0] acc_ff;
   logic [4:0]         age_ff;  // age of the tap whose read is in flight

   logic [WAW-1:0] w_rd_addr, w_wr_addr;
   logic [HAW-1:0] h_rd_addr, h_wr_addr, h_sh_addr;
   logic signed [15:0] w_rd, h_rd, h_wr_data;
   logic [4:0] age_c;
   logic signed [31:0] gprod;
   logic signed [15:0] v_c;
   logic signed [40:0] rnd;

   always_comb begin
      age_c     = taps_k - 5'd1 - tap_idx;
      w_rd_addr = WAW'(ch_ff * KERNEL + tap_idx);
      w_wr_addr = WAW'(ch_ff * KERNEL + tap_ff);
      h_rd_addr = HAW'(ch_ff * SLOTS + ((age_c == 0) ? 0 : age_c - 1));
      // shift writes walk from oldest down; tap_idx reuses as slot number
      // the read is issued the cycle before its write, two slots below the current write
      h_wr_addr = HAW'(ch_ff * SLOTS + tap_idx);
      h_sh_addr = HAW'(ch_ff * SLOTS + tap_idx - 5'd2);
      h_wr_data = (tap_idx == 0) ? g_ff : h_rd;
      gprod     = a_ff * $signed({1'b0, SIGMOID_TABLE[b_ff[15:8] + 8'd128]});
      v_c       = (age_ff == 0) ? g_ff : ((age_ff <= frames) ? h_rd : 16'sd0);
      rnd       = (acc_ff + 41'sd8192) >>> 14;
   end

   gcdc_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wt (
      .clock(clock), .wr_en(cmd.wt_wr), .wr_addr(w_wr_addr), .wr_data(wt_ff),
      .rd_addr(w_rd_addr), .rd_data(w_rd));
   gcdc_ram #(.WIDTH(16), .DEPTH(HDEPTH)) u_hist (
      .clock(clock), .wr_en(cmd.hist_wr), .wr_addr(h_wr_addr), .wr_data(h_wr_data),
      .rd_addr((cmd.hist_wr || cmd.finish) ? h_sh_addr : h_rd_addr),
      .rd_data(h_rd));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff <= req_channel; tap_ff <= req_tap; wt_ff <= req_tap_weight;
         a_ff <= req_content_half; b_ff <= req_gate_half;
      end
      if (cmd.gate_mul) g_ff <= 16'((gprod + 32'sd16384) >>> 15);
      if (cmd.rd_issue) age_ff <= age_c;
      if (cmd.acc_clear) acc_ff <= '0;
      else if (cmd.mac) acc_ff <= acc_ff + 41'(w_rd * v_c);
      if (cmd.finish) begin
         rsp_out_channel <= ch_ff;
         if (rnd > 41'sd32767) begin
            rsp_conv_out <= 16'sd32767; rsp_saturated <= 1'b1;
         end else if (rnd < -41'sd32768) begin
            rsp_conv_out <= -16'sd32768; rsp_saturated <= 1'b1;
         end else begin
            rsp_conv_out <= rnd[15:0]; rsp_saturated <= 1'b0;
         end
      end
   end
endmodule

### sv/gcdc_ctrl.sv
// controller: sequences load, gating, tap walk, history shift and output
// depends on gcdc_pkg and assert_macros.svh
`include "assert_macros.svh"
module gcdc_ctrl import gcdc_pkg::*; #(
   parameter int CHANNELS = 512,
   parameter int KERNEL   = 9
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_opcode,
   input  logic [8:0]   req_channel,
   input  logic         req_last_channel,
   input  logic         req_new_sequence,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [3:0]   csr_taps_in_use,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output gcdc_cmd_type cmd,
   output logic [4:0]   tap_idx,
   output logic [4:0]   taps_k,
   output logic [4:0]   frames
);
   localparam int SLOTS = KERNEL - 1;
   typedef enum logic [2:0] {S_IDLE, S_LOAD, S_GATE, S_MAC, S_DRAIN, S_SHIFT, S_OUT}
      state_type;
   state_type state_ff, state_in;
   logic [4:0] tap_ff, tap_in, frames_ff, frames_in, k_ff, k_in;
   logic       rsp_valid_ff, rsp_valid_in, last_ff, last_in;
   logic [4:0] kraw;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign tap_idx   = tap_ff;
   assign taps_k    = k_ff;
   assign frames    = frames_ff;

   always_comb begin
      kraw = (csr_taps_in_use == 4'd0) ? 5'd1 : 5'({1'b0, csr_taps_in_use});
      k_in = (csr_valid) ? ((kraw > 5'(KERNEL)) ? 5'(KERNEL) : kraw) : k_ff;
      state_in = state_ff; tap_in = tap_ff; frames_in = frames_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready; last_in = last_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.capture = 1'b1;
            last_in = req_last_channel;
            if (req_opcode == OP_LOAD) state_in = S_LOAD;
            else begin
               if (req_new_sequence) frames_in = '0;
               if (11'(req_channel) < 11'(CHANNELS)) state_in = S_GATE;
               else if (req_last_channel && frames_in < 5'(SLOTS))
                  frames_in = frames_in + 5'd1;
            end
         end
         S_LOAD: begin
            // tap_ff holds zero here; range check done via captured fields
            cmd.wt_wr = 1'b1;
            state_in = S_IDLE;
         end
         S_GATE: begin
            cmd.gate_mul = 1'b1; cmd.acc_clear = 1'b1; cmd.rd_issue = 1'b1;
            tap_in = 5'd1; state_in = S_MAC;
         end
         S_MAC: begin
            cmd.mac = 1'b1; cmd.rd_issue = 1'b1;
            if (tap_ff == k_ff) begin
               cmd.rd_issue = 1'b0; state_in = S_DRAIN;
               tap_in = 5'(SLOTS);
            end else tap_in = tap_ff + 5'd1;
         end
         S_DRAIN: begin
            // wait here while the previous result is still held
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1; rsp_valid_in = 1'b1;
               state_in = (SLOTS > 0) ? S_SHIFT : S_OUT;
               if (SLOTS > 0) tap_in = 5'(SLOTS - 1);
            end
         end
         S_SHIFT: begin
            cmd.hist_wr = 1'b1;
            if (tap_ff == 0) state_in = S_OUT;
            else tap_in = tap_ff - 5'd1;
         end
         S_OUT: begin
            if (last_ff && frames_ff < 5'(SLOTS)) frames_in = frames_ff + 5'd1;
            tap_in = '0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; tap_ff <= '0; frames_ff <= '0;
         k_ff <= 5'(KERNEL); rsp_valid_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; tap_ff <= tap_in; frames_ff <= frames_in;
         k_ff <= k_in; rsp_valid_ff <= rsp_valid_in; last_ff <= last_in;
      end
   end

   `ASSERT_CLK(a_frames_cap, clock, reset, frames_ff <= 5'(SLOTS), "frame count overflow")
   `ASSERT_CLK(a_rsp_from_drain, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DRAIN, "result without drain")
   `ASSERT_CLK(a_no_accept_busy, clock, reset,
      state_ff != S_IDLE |-> !req_ready, "accept while busy")
endmodule

### tb/tb_glu_causal_depthwise_conv.sv
`timescale 1ns / 1ps
// self-checking testbench for glu_causal_depthwise_conv: queued stimulus, a
// clocked driver and monitor, and a local model of the gated depthwise conv
// depends on gcdc_pkg and the glu_causal_depthwise_conv rtl
module tb_glu_causal_depthwise_conv;
   import gcdc_pkg::*;

   localparam int NUM_CH    = 512;
   localparam int TAPS_MAX  = 9;
   localparam int HIST_LEN  = TAPS_MAX - 1;
   localparam int CYCLE_CAP = 2000000;
   localparam int SETTLE    = 60;

   typedef struct {
      logic              opcode;
      logic [8:0]        channel;
      logic [3:0]        tap;
      logic signed [15:0] tap_weight;
      logic signed [15:0] content_half;
      logic signed [15:0] gate_half;
      logic              last_channel;
      logic              new_sequence;
   } req_word_type;

   typedef struct {
      logic [8:0]         channel;
      logic signed [15:0] conv;
      logic               sat;
   } conv_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = OP_LOAD;
   logic [8:0] req_channel = '0;
   logic [3:0] req_tap = '0;
   logic signed [15:0] req_tap_weight = '0;
   logic signed [15:0] req_content_half = '0;
   logic signed [15:0] req_gate_half = '0;
   logic req_last_channel = 1'b0;
   logic req_new_sequence = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [8:0] rsp_out_channel;
   logic signed [15:0] rsp_conv_out;
   logic rsp_saturated;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_taps_in_use = 4'd9;

   glu_causal_depthwise_conv uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_channel(req_channel), .req_tap(req_tap), .req_tap_weight(req_tap_weight),
      .req_content_half(req_content_half), .req_gate_half(req_gate_half),
      .req_last_channel(req_last_channel), .req_new_sequence(req_new_sequence),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_channel(rsp_out_channel),
      .rsp_conv_out(rsp_conv_out), .rsp_saturated(rsp_saturated),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_taps_in_use(csr_taps_in_use)
   );

   always #5 clock = ~clock;

   // model state
   logic [15:0]        sig_lut [256];
   logic signed [15:0] tap_weights [NUM_CH][TAPS_MAX];
   logic signed [15:0] gated_hist [NUM_CH][HIST_LEN];
   int unsigned        frame_count;
   logic [3:0]         taps_reg;

   req_word_type    pending_words[$];
   conv_result_type conv_expected[$];
   int  errors = 0;
   int  cycles = 0;
   int  results_seen = 0;
   bit  req_fire = 0;
   bit  hold_done = 0;
   int  hold_left = 0;

   // fixed channel set: 0 and 511 cover every channel bit, plus alternating patterns
   int chan_set[5] = '{0, 1, 170, 341, 511};

   // no random idling inside this window
   function automatic bit busy_window();
      return cycles >= 6000 && cycles < 10000;
   endfunction

   function automatic bit idle_now();
      return !busy_window() && ($urandom_range(99) < 18);
   endfunction

   task automatic build_sig_lut();
      logic [63:0] e;
      logic [63:0] pos;
      e = 64'd4162825044;
      for (int j = 0; j < 128; j++) begin
         pos = (((64'd1 << 48) / ((64'd1 << 32) + e)) + 64'd1) >> 1;
         sig_lut[128 + j] = (pos > 64'd32767) ? 16'd32767 : pos[15:0];
         sig_lut[127 - j] = 16'(64'd32768 - pos);
         e = (e * 64'd4034748382 + 64'h8000_0000) >> 32;
      end
   endtask

   // updates model state for one accepted word, queues the result if any
   task automatic predict_conv(input req_word_type w);
      longint a, g, acc, r, v;
      int k, age;
      logic [7:0] idx;
      conv_result_type res;
      if (w.opcode == OP_LOAD) begin
         if (w.tap < TAPS_MAX) tap_weights[w.channel][w.tap] = w.tap_weight;
         return;
      end
      if (w.new_sequence) frame_count = 0;
      a = w.content_half;
      idx = w.gate_half[15:8] ^ 8'h80;
      g = (a * longint'(sig_lut[idx]) + 16384) >>> 15;
      k = (taps_reg == 0) ? 1 : (taps_reg > TAPS_MAX ? TAPS_MAX : taps_reg);
      acc = 0;
      for (int j = 0; j < k; j++) begin
         age = k - 1 - j;
         if (age == 0) v = g;
         else if (age <= frame_count) v = gated_hist[w.channel][age - 1];
         else v = 0;
         acc += longint'(tap_weights[w.channel][j]) * v;
      end
      r = (acc + 8192) >>> 14;
      res.sat = 1'b0;
      if (r > 32767) begin r = 32767; res.sat = 1'b1; end
      if (r < -32768) begin r = -32768; res.sat = 1'b1; end
      for (int j = HIST_LEN - 1; j > 0; j--) gated_hist[w.channel][j] = gated_hist[w.channel][j - 1];
      gated_hist[w.channel][0] = 16'(g);
      res.channel = w.channel;
      res.conv = 16'(r);
      conv_expected.push_back(res);
      if (w.last_channel && frame_count < HIST_LEN) frame_count++;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   task automatic push_load(input int ch, input int tap, input int wt);
      req_word_type w;
      w.opcode = OP_LOAD;
      w.channel = 9'(ch);
      w.tap = 4'(tap);
      w.tap_weight = 16'(wt);
      w.content_half = 16'($urandom);
      w.gate_half = 16'($urandom);
      // flags mean nothing on a load
      w.last_channel = 1'($urandom_range(1));
      w.new_sequence = 1'($urandom_range(1));
      pending_words.push_back(w);
   endtask

   task automatic push_sample(input int ch, input int a, input int b,
                              input bit last, input bit fresh);
      req_word_type w;
      w.opcode = OP_SAMPLE;
      w.channel = 9'(ch);
      w.tap = 4'($urandom);
      w.tap_weight = 16'($urandom);
      w.content_half = 16'(a);
      w.gate_half = 16'(b);
      w.last_channel = last;
      w.new_sequence = fresh;
      pending_words.push_back(w);
   endtask

   function automatic int rand_half();
      case ($urandom_range(9))
         0: return 32767;
         1: return -32768;
         2: return 0;
         3: return -1;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   // one frame over the channel set; noise flags only when noisy is set
   task automatic send_frame(input bit fresh, input bit noisy);
      bit last, seq;
      for (int i = 0; i < 5; i++) begin
         last = (i == 4);
         seq = fresh && (i == 0);
         if (noisy && $urandom_range(99) < 6) begin
            last = 1'($urandom_range(1));
            seq = 1'($urandom_range(1));
         end
         push_sample(chan_set[i], rand_half(), rand_half(), last, seq);
      end
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || conv_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_taps(input int val);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_taps_in_use <= 4'(val);
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // model mirrors the register at the accepting edge
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) taps_reg <= csr_taps_in_use;
   end

   // input driver
   always @(posedge clock) req_fire <= !reset && req_valid && req_ready;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_words.size() != 0 && !idle_now()) begin
            req_word_type w;
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_opcode <= w.opcode;
            req_channel <= w.channel;
            req_tap <= w.tap;
            req_tap_weight <= w.tap_weight;
            req_content_half <= w.content_half;
            req_gate_half <= w.gate_half;
            req_last_channel <= w.last_channel;
            req_new_sequence <= w.new_sequence;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // accepted word goes into the model at the same edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         req_word_type w;
         w.opcode = req_opcode;
         w.channel = req_channel;
         w.tap = req_tap;
         w.tap_weight = req_tap_weight;
         w.content_half = req_content_half;
         w.gate_half = req_gate_half;
         w.last_channel = req_last_channel;
         w.new_sequence = req_new_sequence;
         predict_conv(w);
      end
   end

   // receiver: random idling plus one long hold-off so the block backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 60) begin
         hold_done <= 1'b1;
         hold_left <= 600;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !idle_now();
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (conv_expected.size() == 0) begin
            report_mismatch("unexpected result channel", rsp_out_channel, -1);
         end else begin
            conv_result_type x;
            x = conv_expected.pop_front();
            if (rsp_out_channel !== x.channel) report_mismatch("channel", rsp_out_channel, x.channel);
            if (rsp_conv_out !== x.conv) report_mismatch("conv_out", rsp_conv_out, x.conv);
            if (rsp_saturated !== x.sat) report_mismatch("saturated", rsp_saturated, x.sat);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   int phase_taps[8] = '{9, 1, 0, 15, 10, 3, 7, 5};

   initial begin
      build_sig_lut();
      frame_count = 0;
      taps_reg = 4'd9;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extreme weights, extreme samples, ignored tap indexes
      write_taps(9);
      for (int t = 0; t < TAPS_MAX; t++) begin
         push_load(0, t, 32767);
         push_load(511, t, -32768);
         push_load(1, t, (t == 0) ? 16384 : 0);
         push_load(170, t, 16384);
         push_load(341, t, -16384);
      end
      push_load(0, 9, -5);
      push_load(511, 15, 7);
      push_sample(0, 32767, 32767, 0, 1);
      push_sample(1, -32768, -32768, 0, 0);
      push_sample(170, -32768, 32767, 0, 0);
      push_sample(341, 32767, -1, 0, 0);
      push_sample(511, 32767, 0, 1, 0);
      for (int f = 0; f < 9; f++) send_frame(0, 0);

      // random phases across several register settings
      for (int p = 0; p < 8; p++) begin
         write_taps(p == 7 ? $urandom_range(15) : phase_taps[p]);
         for (int f = 0; f < 32; f++) begin
            if ($urandom_range(99) < 20)
               push_load(chan_set[$urandom_range(4)],
                         ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(8),
                         rand_half());
            send_frame($urandom_range(99) < 8, 1);
         end
      end

      wait_idle();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
